// File: src/jdcc_pkg.sv
// jdcc_pkg: shared types, constants and month tables for the julian day converter.
// No dependencies; imported by jdcc_flow, julian_day_calendar_converter_core and the testbench.
package jdcc_pkg;

    localparam int NSTG = 8;

    localparam logic [22:0] MAX_DAY_NUMBER = 23'd5373484;
    localparam logic [23:0] DAY_CS         = 24'd8640000;
    localparam int          GREG_START     = 2299161;
    localparam int          REFORM_YEAR    = 1582;
    localparam int          REFORM_SHIFT   = 10;
    localparam int          EPOCH_YEAR     = 4712;
    localparam int          DAY_OFFSET     = 1721087;
    // day offset for january 0 (month 13 of the year before)
    localparam int          JAN0_OFFSET    = 1721087 + 336;
    localparam int          YEAR_TENTHOUS  = 3652422;

    // reciprocals for constant division
    localparam logic [19:0] RCP_27   = 20'd621379;    // 2^24 / 27
    localparam logic [19:0] RCP_375  = 20'd715828;    // 2^28 / 375
    localparam logic [10:0] RCP_60   = 11'd1093;      // 2^16 / 60
    localparam logic [12:0] RCP_100  = 13'd5243;      // 2^19 / 100
    localparam logic [23:0] RCP_YEAR = 24'd11759231;  // 2^32 * 10000 / 3652422

    typedef enum logic {
        OP_CAL_TO_DAY = 1'b0,
        OP_DAY_TO_CAL = 1'b1
    } t_op;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

    // floor(3059 * n / 100) for shifted month n = 1..12
    function automatic logic [8:0] month_offset(input logic [3:0] n);
        logic [8:0] v;
        case (n)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // days in the year through the end of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd0;
        endcase
        if (leap && m >= 4'd2) begin
            v = v + 9'd1;
        end
        return v;
    endfunction

endpackage

// File: src/julian_day_calendar_converter_core.sv
// julian_day_calendar_converter_core: calendar date <-> julian day number converter.
// Depends on jdcc_pkg and jdcc_flow.
//
// Takes one word per cycle while o_stall is low and returns each result in order.
// Every pipeline stage holds one word and moves when the stage after it can take
// it, so bubbles close up under a downstream stall and a new word is accepted as
// long as any stage is free. Operation 0 turns year/month/day/time into a day
// number and centiseconds since midnight; operation 1 turns a day number and
// time back into a date. The year estimate uses a reciprocal multiply corrected
// by remainder compares; the month is found by comparing against all twelve
// month ends at once in the last stage.
module julian_day_calendar_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [14:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day_of_month,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic [12:0] i_centisecond,
    input  logic [22:0] i_day_number,
    input  logic [23:0] i_time_of_day_cs,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [22:0] o_out_day_number,
    output logic [23:0] o_out_time_cs,
    output logic [14:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [12:0] o_out_centisecond,
    output logic        o_range_error
);
    import jdcc_pkg::*;

    t_pipe_ctl w_ctl;

    jdcc_flow u_flow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    // ---------------- stage 1: decode, checks, first multiplies
    t_op                r_s1_op, n_s1_op;
    logic               r_s1_err, n_s1_err;
    logic signed [15:0] r_s1_y, n_s1_y;
    logic [8:0]         r_s1_b, n_s1_b;
    logic signed [25:0] r_s1_p1461, n_s1_p1461;
    logic [4:0]         r_s1_day, n_s1_day;
    logic [23:0]        r_s1_tcs, n_s1_tcs;
    logic [22:0]        r_s1_dn, n_s1_dn;
    logic [23:0]        r_s1_t, n_s1_t;
    logic [13:0]        r_s1_tq, n_s1_tq;
    logic [14:0]        r_s1_qe, n_s1_qe;
    logic [10:0]        r_s1_tm, n_s1_tm;

    logic signed [15:0] w_yr;
    logic               w_mle2;
    logic [3:0]         w_mm2;
    logic [38:0]        w_prod_tq;
    logic [46:0]        w_prod_qe;
    logic [39:0]        w_prod_tm;

    always_comb begin
        w_yr   = {i_year[14], i_year};
        w_mle2 = i_month <= 4'd2;
        w_mm2  = w_mle2 ? i_month + 4'd10 : i_month - 4'd2;
        n_s1_op    = t_op'(i_operation);
        n_s1_y     = w_yr - (w_mle2 ? 16'sd1 : 16'sd0);
        n_s1_b     = month_offset(w_mm2);
        n_s1_p1461 = n_s1_y * 26'sd1461;
        n_s1_day   = i_day_of_month;
        n_s1_tcs   = 24'(i_hour) * 24'd360000 + 24'(i_minute) * 24'd6000
                   + 24'(i_centisecond);
        n_s1_dn    = i_day_number;
        n_s1_t     = i_time_of_day_cs;
        // t / 864 = (t / 32) / 27
        w_prod_tq  = 39'(i_time_of_day_cs[23:5]) * 39'(RCP_27);
        n_s1_tq    = w_prod_tq[37:24];
        // year estimate, off by at most one
        w_prod_qe  = 47'(i_day_number) * 47'(RCP_YEAR);
        n_s1_qe    = w_prod_qe[46:32];
        // whole minutes: t / 6000 = (t / 16) / 375
        w_prod_tm  = 40'(i_time_of_day_cs[23:4]) * 40'(RCP_375);
        n_s1_tm    = w_prod_tm[38:28];
        if (n_s1_op == OP_CAL_TO_DAY) begin
            n_s1_err = (w_yr < -16'sd4712) || (w_yr > 16'sd9999) || (i_month == 4'd0)
                     || (i_month > 4'd12) || (i_hour > 5'd23) || (i_minute > 6'd59)
                     || (i_centisecond > 13'd5999);
        end else begin
            n_s1_err = (i_day_number > MAX_DAY_NUMBER) || (i_time_of_day_cs >= DAY_CS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_s1_op    <= n_s1_op;
            r_s1_err   <= n_s1_err;
            r_s1_y     <= n_s1_y;
            r_s1_b     <= n_s1_b;
            r_s1_p1461 <= n_s1_p1461;
            r_s1_day   <= n_s1_day;
            r_s1_tcs   <= n_s1_tcs;
            r_s1_dn    <= n_s1_dn;
            r_s1_t     <= n_s1_t;
            r_s1_tq    <= n_s1_tq;
            r_s1_qe    <= n_s1_qe;
            r_s1_tm    <= n_s1_tm;
        end
    end

    // ---------------- stage 2: uncorrected day number, scaled day, hour
    t_op                r_s2_op;
    logic               r_s2_err;
    logic signed [25:0] r_s2_k0, n_s2_k0;
    logic [6:0]         r_s2_y100, n_s2_y100;
    logic               r_s2_yneg;
    logic [23:0]        r_s2_tcs;
    logic signed [36:0] r_s2_v, n_s2_v;
    logic [36:0]        r_s2_p, n_s2_p;
    logic [14:0]        r_s2_qe;
    logic [22:0]        r_s2_dn;
    logic [10:0]        r_s2_tm;
    logic [4:0]         r_s2_hour, n_s2_hour;
    logic [12:0]        r_s2_cs, n_s2_cs;

    logic signed [25:0] w_a;
    logic [26:0]        w_prod_y100;
    logic [21:0]        w_prod_hr;
    logic [23:0]        w_rem_cs;

    always_comb begin
        // division by four toward zero
        if (r_s1_p1461 < 0) begin
            w_a = (r_s1_p1461 + 26'sd3) >>> 2;
        end else begin
            w_a = r_s1_p1461 >>> 2;
        end
        n_s2_k0     = w_a + $signed({17'd0, r_s1_b}) + $signed({21'd0, r_s1_day})
                    + 26'(DAY_OFFSET);
        w_prod_y100 = 27'(r_s1_y[13:0]) * 27'(RCP_100);
        n_s2_y100   = w_prod_y100[25:19];
        // floor(z / 864) with z = 8640000*dn - 4320000 + t
        n_s2_v      = $signed(37'(r_s1_dn) * 37'd10000 + 37'(r_s1_tq) - 37'd5000);
        n_s2_p      = 37'(r_s1_qe) * 37'(YEAR_TENTHOUS);
        w_prod_hr   = 22'(r_s1_tm) * 22'(RCP_60);
        n_s2_hour   = w_prod_hr[20:16];
        w_rem_cs    = r_s1_t - 24'(r_s1_tm) * 24'd6000;
        n_s2_cs     = w_rem_cs[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[1]) begin
            r_s2_op   <= r_s1_op;
            r_s2_err  <= r_s1_err;
            r_s2_k0   <= n_s2_k0;
            r_s2_y100 <= n_s2_y100;
            r_s2_yneg <= r_s1_y[15];
            r_s2_tcs  <= r_s1_tcs;
            r_s2_v    <= n_s2_v;
            r_s2_p    <= n_s2_p;
            r_s2_qe   <= r_s1_qe;
            r_s2_dn   <= r_s1_dn;
            r_s2_tm   <= r_s1_tm;
            r_s2_hour <= n_s2_hour;
            r_s2_cs   <= n_s2_cs;
        end
    end

    // ---------------- stage 3: gregorian correction, year from remainder
    t_op                r_s3_op;
    logic               r_s3_err, n_s3_err;
    logic [22:0]        r_s3_k, n_s3_k;
    logic [23:0]        r_s3_tcs;
    logic signed [15:0] r_s3_y0, n_s3_y0;
    logic [22:0]        r_s3_dn;
    logic               r_s3_greg, n_s3_greg;
    logic [4:0]         r_s3_hour;
    logic [5:0]         r_s3_min, n_s3_min;
    logic [12:0]        r_s3_cs;

    logic signed [25:0] w_k;
    logic signed [37:0] w_r;
    logic signed [15:0] w_q;
    logic [10:0]        w_min_full;

    always_comb begin
        if (r_s2_k0 >= 26'(GREG_START)) begin
            w_k = r_s2_k0 + $signed({21'd0, r_s2_y100[6:2]}) - $signed({19'd0, r_s2_y100})
                + 26'sd2;
        end else if (r_s2_yneg) begin
            w_k = r_s2_k0 - 26'sd1;
        end else begin
            w_k = r_s2_k0;
        end
        n_s3_k = w_k[22:0];
        if (r_s2_op == OP_CAL_TO_DAY) begin
            n_s3_err = r_s2_err || (w_k < 0) || (w_k > $signed({3'd0, MAX_DAY_NUMBER}));
        end else begin
            n_s3_err = r_s2_err;
        end
        w_r = {r_s2_v[36], r_s2_v} - $signed({1'b0, r_s2_p});
        if (w_r < 0) begin
            w_q = $signed({1'b0, r_s2_qe}) - 16'sd1;
        end else if (w_r >= 38'(YEAR_TENTHOUS)) begin
            w_q = $signed({1'b0, r_s2_qe}) + 16'sd1;
        end else begin
            w_q = $signed({1'b0, r_s2_qe});
        end
        n_s3_y0    = w_q - 16'(EPOCH_YEAR);
        n_s3_greg  = r_s2_dn >= 23'(GREG_START);
        w_min_full = r_s2_tm - 11'(r_s2_hour) * 11'd60;
        n_s3_min   = w_min_full[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[2]) begin
            r_s3_op   <= r_s2_op;
            r_s3_err  <= n_s3_err;
            r_s3_k    <= n_s3_k;
            r_s3_tcs  <= r_s2_tcs;
            r_s3_y0   <= n_s3_y0;
            r_s3_dn   <= r_s2_dn;
            r_s3_greg <= n_s3_greg;
            r_s3_hour <= r_s2_hour;
            r_s3_min  <= n_s3_min;
            r_s3_cs   <= r_s2_cs;
        end
    end

    // ---------------- stage 4: multiplies for january 0 of the estimated year
    t_op                r_s4_op;
    logic               r_s4_err;
    logic [22:0]        r_s4_k;
    logic [23:0]        r_s4_tcs;
    logic signed [15:0] r_s4_y0;
    logic signed [15:0] r_s4_yy, n_s4_yy;
    logic signed [26:0] r_s4_m1461, n_s4_m1461;
    logic [6:0]         r_s4_yy100, n_s4_yy100;
    logic [6:0]         r_s4_y0100, n_s4_y0100;
    logic [22:0]        r_s4_dn;
    logic               r_s4_greg;
    logic [4:0]         r_s4_hour;
    logic [5:0]         r_s4_min;
    logic [12:0]        r_s4_cs;

    logic [26:0]        w_prod_yy;
    logic [26:0]        w_prod_y0;

    always_comb begin
        n_s4_yy    = r_s3_y0 - 16'sd1;
        n_s4_m1461 = n_s4_yy * 27'sd1461;
        w_prod_yy  = 27'(n_s4_yy[13:0]) * 27'(RCP_100);
        n_s4_yy100 = w_prod_yy[25:19];
        w_prod_y0  = 27'(r_s3_y0[13:0]) * 27'(RCP_100);
        n_s4_y0100 = w_prod_y0[25:19];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[3]) begin
            r_s4_op    <= r_s3_op;
            r_s4_err   <= r_s3_err;
            r_s4_k     <= r_s3_k;
            r_s4_tcs   <= r_s3_tcs;
            r_s4_y0    <= r_s3_y0;
            r_s4_yy    <= n_s4_yy;
            r_s4_m1461 <= n_s4_m1461;
            r_s4_yy100 <= n_s4_yy100;
            r_s4_y0100 <= n_s4_y0100;
            r_s4_dn    <= r_s3_dn;
            r_s4_greg  <= r_s3_greg;
            r_s4_hour  <= r_s3_hour;
            r_s4_min   <= r_s3_min;
            r_s4_cs    <= r_s3_cs;
        end
    end

    // ---------------- stage 5: uncorrected january 0, leap rule
    t_op                r_s5_op;
    logic               r_s5_err;
    logic [22:0]        r_s5_k;
    logic [23:0]        r_s5_tcs;
    logic signed [15:0] r_s5_y0;
    logic               r_s5_yyneg;
    logic signed [26:0] r_s5_kj, n_s5_kj;
    logic [6:0]         r_s5_yy100;
    logic               r_s5_leap, n_s5_leap;
    logic [22:0]        r_s5_dn;
    logic               r_s5_greg;
    logic [4:0]         r_s5_hour;
    logic [5:0]         r_s5_min;
    logic [12:0]        r_s5_cs;

    logic signed [26:0] w_a2;
    logic [15:0]        w_m100;
    logic               w_gleap;
    logic               w_jleap;

    always_comb begin
        if (r_s4_m1461 < 0) begin
            w_a2 = (r_s4_m1461 + 27'sd3) >>> 2;
        end else begin
            w_a2 = r_s4_m1461 >>> 2;
        end
        n_s5_kj = w_a2 + 27'(JAN0_OFFSET);
        w_m100  = r_s4_y0 - 16'(r_s4_y0100) * 16'd100;
        w_gleap = (w_m100 == 16'd0) ? (r_s4_y0100[1:0] == 2'd0) : (r_s4_y0[1:0] == 2'd0);
        // before the reform negative years are leap when year - 1 divides by four
        w_jleap = r_s4_y0[15] ? (r_s4_yy[1:0] == 2'd0) : (r_s4_y0[1:0] == 2'd0);
        n_s5_leap = r_s4_greg ? w_gleap : w_jleap;
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[4]) begin
            r_s5_op    <= r_s4_op;
            r_s5_err   <= r_s4_err;
            r_s5_k     <= r_s4_k;
            r_s5_tcs   <= r_s4_tcs;
            r_s5_y0    <= r_s4_y0;
            r_s5_yyneg <= r_s4_yy[15];
            r_s5_kj    <= n_s5_kj;
            r_s5_yy100 <= r_s4_yy100;
            r_s5_leap  <= n_s5_leap;
            r_s5_dn    <= r_s4_dn;
            r_s5_greg  <= r_s4_greg;
            r_s5_hour  <= r_s4_hour;
            r_s5_min   <= r_s4_min;
            r_s5_cs    <= r_s4_cs;
        end
    end

    // ---------------- stage 6: corrected january 0
    t_op                r_s6_op;
    logic               r_s6_err;
    logic [22:0]        r_s6_k;
    logic [23:0]        r_s6_tcs;
    logic signed [15:0] r_s6_y0;
    logic signed [26:0] r_s6_kjan, n_s6_kjan;
    logic               r_s6_leap;
    logic [22:0]        r_s6_dn;
    logic               r_s6_greg;
    logic [4:0]         r_s6_hour;
    logic [5:0]         r_s6_min;
    logic [12:0]        r_s6_cs;

    always_comb begin
        if (r_s5_kj >= 27'(GREG_START)) begin
            n_s6_kjan = r_s5_kj + $signed({22'd0, r_s5_yy100[6:2]})
                      - $signed({20'd0, r_s5_yy100}) + 27'sd2;
        end else if (r_s5_yyneg) begin
            n_s6_kjan = r_s5_kj - 27'sd1;
        end else begin
            n_s6_kjan = r_s5_kj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[5]) begin
            r_s6_op   <= r_s5_op;
            r_s6_err  <= r_s5_err;
            r_s6_k    <= r_s5_k;
            r_s6_tcs  <= r_s5_tcs;
            r_s6_y0   <= r_s5_y0;
            r_s6_kjan <= n_s6_kjan;
            r_s6_leap <= r_s5_leap;
            r_s6_dn   <= r_s5_dn;
            r_s6_greg <= r_s5_greg;
            r_s6_hour <= r_s5_hour;
            r_s6_min  <= r_s5_min;
            r_s6_cs   <= r_s5_cs;
        end
    end

    // ---------------- stage 7: day of year
    t_op                r_s7_op;
    logic               r_s7_err;
    logic [22:0]        r_s7_k;
    logic [23:0]        r_s7_tcs;
    logic signed [15:0] r_s7_y0;
    logic signed [11:0] r_s7_d, n_s7_d;
    logic               r_s7_leap;
    logic [4:0]         r_s7_hour;
    logic [5:0]         r_s7_min;
    logic [12:0]        r_s7_cs;

    logic signed [26:0] w_doy;

    always_comb begin
        w_doy = $signed({4'd0, r_s6_dn}) - r_s6_kjan;
        // reform year: gregorian dates sit ten days further into the year
        if (r_s6_greg && r_s6_y0 == 16'(REFORM_YEAR)) begin
            w_doy = w_doy + 27'(REFORM_SHIFT);
        end
        n_s7_d = w_doy[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[6]) begin
            r_s7_op   <= r_s6_op;
            r_s7_err  <= r_s6_err;
            r_s7_k    <= r_s6_k;
            r_s7_tcs  <= r_s6_tcs;
            r_s7_y0   <= r_s6_y0;
            r_s7_d    <= n_s7_d;
            r_s7_leap <= r_s6_leap;
            r_s7_hour <= r_s6_hour;
            r_s7_min  <= r_s6_min;
            r_s7_cs   <= r_s6_cs;
        end
    end

    // ---------------- stage 8: month split, year wrap, output word
    logic [22:0] r_o_dn, n_o_dn;
    logic [23:0] r_o_tcs, n_o_tcs;
    logic [14:0] r_o_year, n_o_year;
    logic [3:0]  r_o_month, n_o_month;
    logic [4:0]  r_o_day, n_o_day;
    logic [4:0]  r_o_hour, n_o_hour;
    logic [5:0]  r_o_min, n_o_min;
    logic [12:0] r_o_cs, n_o_cs;
    logic        r_o_err, n_o_err;

    logic               w_found;
    logic [3:0]         w_mon;
    logic [8:0]         w_base;
    logic signed [11:0] w_dm;
    logic signed [15:0] w_yr_out;

    always_comb begin
        w_found = 1'b0;
        w_mon   = 4'd1;
        w_base  = cum_days(4'd12, r_s7_leap);
        for (int m = 1; m <= 12; m++) begin
            if (!w_found && r_s7_d <= $signed({3'd0, cum_days(4'(m), r_s7_leap)})) begin
                w_found = 1'b1;
                w_mon   = 4'(m);
                w_base  = cum_days(4'(m - 1), r_s7_leap);
            end
        end
        w_dm     = r_s7_d - $signed({3'd0, w_base});
        w_yr_out = r_s7_y0;
        if (!w_found) begin
            // ran past december
            w_yr_out = r_s7_y0 + 16'sd1;
        end
        if (r_s7_d < 12'sd1) begin
            w_yr_out = r_s7_y0 - 16'sd1;
            w_mon    = 4'd12;
            w_dm     = r_s7_d + 12'sd31;
            if (r_s7_d + 12'sd31 < 12'sd1) begin
                w_mon = 4'd11;
                w_dm  = r_s7_d + 12'sd61;
            end
        end

        n_o_dn    = '0;
        n_o_tcs   = '0;
        n_o_year  = '0;
        n_o_month = '0;
        n_o_day   = '0;
        n_o_hour  = '0;
        n_o_min   = '0;
        n_o_cs    = '0;
        n_o_err   = r_s7_err;
        if (!r_s7_err) begin
            if (r_s7_op == OP_CAL_TO_DAY) begin
                n_o_dn  = r_s7_k;
                n_o_tcs = r_s7_tcs;
            end else begin
                n_o_year  = w_yr_out[14:0];
                n_o_month = w_mon;
                n_o_day   = w_dm[4:0];
                n_o_hour  = r_s7_hour;
                n_o_min   = r_s7_min;
                n_o_cs    = r_s7_cs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[7]) begin
            r_o_dn    <= n_o_dn;
            r_o_tcs   <= n_o_tcs;
            r_o_year  <= n_o_year;
            r_o_month <= n_o_month;
            r_o_day   <= n_o_day;
            r_o_hour  <= n_o_hour;
            r_o_min   <= n_o_min;
            r_o_cs    <= n_o_cs;
            r_o_err   <= n_o_err;
        end
    end

    assign o_out_day_number  = r_o_dn;
    assign o_out_time_cs     = r_o_tcs;
    assign o_out_year        = r_o_year;
    assign o_out_month       = r_o_month;
    assign o_out_day         = r_o_day;
    assign o_out_hour        = r_o_hour;
    assign o_out_minute      = r_o_min;
    assign o_out_centisecond = r_o_cs;
    assign o_range_error     = r_o_err;

    // ---------------- checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid word right after reset");

    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_out_day_number == 23'd0 && o_out_time_cs == 24'd0
            && o_out_year == 15'd0 && o_out_month == 4'd0 && o_out_day == 5'd0)
        else $error("range error with nonzero result fields");

    a_op_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_month != 4'd0 |-> o_out_day_number == 23'd0
            && o_out_time_cs == 24'd0 && o_out_month <= 4'd12)
        else $error("date result mixed with day number result");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_ctl.vld) && i_stall |-> o_stall)
        else $error("full pipeline accepts a word under output stall");

endmodule

// File: src/jdcc_flow.sv
// jdcc_flow: valid bits and per-stage enables of the converter pipeline.
// Depends on jdcc_pkg; a stage moves when it is empty or the next one moves.
module jdcc_flow (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    output logic                o_stall,
    output logic                o_valid,
    output jdcc_pkg::t_pipe_ctl o_ctl
);
    import jdcc_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_en;

    always_comb begin
        n_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int s = NSTG - 2; s >= 0; s--) begin
            n_en[s] = !r_vld[s] || n_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (n_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_stall   = !n_en[0];
    assign o_valid   = r_vld[NSTG-1];
    assign o_ctl.en  = n_en;
    assign o_ctl.vld = r_vld;

endmodule

// File: sim/tb_julian_day_calendar_converter_core.sv
// tb_julian_day_calendar_converter_core: directed table plus random traffic through the
// date/day-number converter, every result checked against a behavioral calculation.
// Depends on jdcc_pkg and julian_day_calendar_converter_core.
module tb_julian_day_calendar_converter_core;
    timeunit 1ns;
    timeprecision 1ps;
    import jdcc_pkg::*;

    typedef struct packed {
        logic        op;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  dom;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [12:0] csec;
        logic [22:0] dnum;
        logic [23:0] tod;
    } t_req;

    typedef struct packed {
        logic [22:0] dnum;
        logic [23:0] tcs;
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [12:0] csec;
        logic        rerr;
    } t_date_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid;
    t_req        req = '0;
    t_date_out   got;

    julian_day_calendar_converter_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(req.op), .i_year(req.year), .i_month(req.month),
        .i_day_of_month(req.dom), .i_hour(req.hour), .i_minute(req.minute),
        .i_centisecond(req.csec), .i_day_number(req.dnum), .i_time_of_day_cs(req.tod),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_day_number(got.dnum), .o_out_time_cs(got.tcs), .o_out_year(got.year),
        .o_out_month(got.month), .o_out_day(got.day), .o_out_hour(got.hour),
        .o_out_minute(got.minute), .o_out_centisecond(got.csec), .o_range_error(got.rerr)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_date_out pending_dates[$];
    int        n_bad = 0;
    bit        quiet = 0;

    function automatic longint day_of(longint y, longint m, longint d);
        longint k;
        if (m <= 2) begin
            m += 12;
            y -= 1;
        end
        k = (1461 * y) / 4 + (3059 * (m - 2)) / 100 + d + DAY_OFFSET;
        if (k >= GREG_START) k += y / 400 - y / 100 + 2;
        else if (y < 0) k -= 1;
        return k;
    endfunction

    function automatic t_date_out convert_date(t_req r);
        t_date_out o;
        longint y, m, d, k, t, x, y0, lim;
        longint mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        bit greg, leap;
        o = '0;
        if (r.op == OP_CAL_TO_DAY) begin
            y = longint'($signed(r.year));
            m = r.month;
            d = r.dom;
            if (y < -4712 || y > 9999 || m < 1 || m > 12 || r.hour > 23 || r.minute > 59
                    || r.csec > 5999) begin
                o.rerr = 1'b1;
                return o;
            end
            k = day_of(y, m, d);
            if (k < 0 || k > MAX_DAY_NUMBER) begin
                o.rerr = 1'b1;
                return o;
            end
            o.dnum = k[22:0];
            t = r.hour * 360000 + r.minute * 6000 + r.csec;
            o.tcs = t[23:0];
        end else begin
            k = r.dnum;
            t = r.tod;
            if (k > MAX_DAY_NUMBER || t >= DAY_CS) begin
                o.rerr = 1'b1;
                return o;
            end
            x = ((2 * k - 1) * DAY_CS + 2 * t) * 10000;
            lim = longint'(17280000) * YEAR_TENTHOUS;
            y0 = (x >= 0) ? x / lim : -((-x + lim - 1) / lim);
            y0 -= EPOCH_YEAR;
            d = k - day_of(y0, 1, 0);
            greg = k >= GREG_START;
            if (y0 == REFORM_YEAR && greg) d += REFORM_SHIFT;
            if (greg) leap = (y0 % 400 == 0) || (y0 % 100 != 0 && y0 % 4 == 0);
            else if (y0 >= 0) leap = (y0 % 4 == 0);
            else leap = ((y0 - 1) % 4 == 0);
            y = y0;
            for (m = 1; m <= 12; m++) begin
                lim = mlen[m - 1] + ((m == 2 && leap) ? 1 : 0);
                if (d <= lim) break;
                d -= lim;
            end
            if (m == 13) begin
                y += 1;
                m = 1;
            end
            if (d < 1) begin
                y -= 1;
                m = 12;
                d += 31;
                if (d < 1) begin
                    m = 11;
                    d += 30;
                end
            end
            o.year = y[14:0];
            o.month = m[3:0];
            o.day = d[4:0];
            o.hour = 5'(t / 360000);
            o.minute = 6'((t % 360000) / 6000);
            o.csec = 13'(t % 6000);
        end
        return o;
    endfunction

    function automatic t_req cal_req(int y, int m, int d, int h, int mi, int cs);
        t_req r;
        r = '0;
        r.op = OP_CAL_TO_DAY;
        r.year = 15'(y);
        r.month = 4'(m);
        r.dom = 5'(d);
        r.hour = 5'(h);
        r.minute = 6'(mi);
        r.csec = 13'(cs);
        return r;
    endfunction

    function automatic t_req day_req(int k, int t);
        t_req r;
        r = '0;
        r.op = OP_DAY_TO_CAL;
        r.dnum = 23'(k);
        r.tod = 24'(t);
        return r;
    endfunction

    // random content in every field, biased toward legal values of the chosen op
    function automatic t_req rand_req();
        t_req r;
        r = t_req'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) != 0) begin
            if (r.op == OP_CAL_TO_DAY) begin
                case ($urandom_range(0, 3))
                    0: r.year = 15'($urandom_range(0, 14711) - 4712);
                    1: r.year = 15'($urandom_range(1570, 1600));
                    2: r.year = 15'($urandom_range(0, 40) - 20);
                    default: r.year = 15'($urandom_range(0, 14711) - 4712);
                endcase
                r.month = 4'($urandom_range(1, 12));
                r.hour = 5'($urandom_range(0, 23));
                r.minute = 6'($urandom_range(0, 59));
                r.csec = 13'($urandom_range(0, 5999));
            end else begin
                case ($urandom_range(0, 3))
                    0: r.dnum = 23'($urandom_range(2299100, 2299220));
                    1: r.dnum = 23'($urandom_range(1700000, 1740000));
                    default: r.dnum = 23'($urandom_range(0, 5373484));
                endcase
                r.tod = 24'($urandom_range(0, 8639999));
            end
        end
        return r;
    endfunction

    task automatic send_word(t_req r, bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req <= r;
        i_valid <= 1'b1;
        pending_dates.push_back(convert_date(r));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver: stall bursts while allowed, compare at each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result word %h", got);
            end else begin
                t_date_out want;
                want = pending_dates.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10) $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    t_req      dir_req[$];
    t_date_out dir_want[$];
    bit        dir_known[$];

    task automatic add_row(t_req r, bit known, t_date_out w);
        dir_req.push_back(r);
        dir_known.push_back(known);
        dir_want.push_back(w);
    endtask

    initial begin
        t_date_out err_word, none;
        int        wait_cnt;
        err_word = '0;
        err_word.rerr = 1'b1;
        none = '0;
        add_row(cal_req(-4712, 1, 1, 12, 0, 0), 1, '{0, 4320000, 0, 0, 0, 0, 0, 0, 0});
        add_row(cal_req(-4713, 1, 1, 0, 0, 0), 1, err_word);
        add_row(cal_req(2000, 0, 1, 0, 0, 0), 1, err_word);
        add_row(cal_req(2000, 13, 1, 0, 0, 0), 1, err_word);
        add_row(cal_req(2000, 1, 1, 24, 0, 0), 1, err_word);
        add_row(cal_req(2000, 1, 1, 0, 60, 0), 1, err_word);
        add_row(cal_req(2000, 1, 1, 0, 0, 6000), 1, err_word);
        add_row(cal_req(10000, 1, 1, 0, 0, 0), 1, err_word);
        add_row(cal_req(-4712, 1, 0, 0, 0, 0), 1, err_word);
        add_row(cal_req(9999, 12, 31, 23, 59, 5999), 0, none);
        add_row(cal_req(1582, 10, 4, 0, 0, 0), 0, none);
        add_row(cal_req(1582, 10, 5, 0, 0, 0), 0, none);
        add_row(cal_req(1582, 10, 15, 0, 0, 0), 0, none);
        add_row(cal_req(-1, 3, 0, 0, 0, 0), 0, none);
        add_row(cal_req(0, 2, 29, 0, 0, 0), 0, none);
        add_row(cal_req(2024, 2, 31, 31, 63, 8191), 1, err_word);
        add_row(day_req(0, 0), 0, none);
        add_row(day_req(5373484, 8639999), 0, none);
        add_row(day_req(5373485, 0), 1, err_word);
        add_row(day_req(0, 8640000), 1, err_word);
        add_row(day_req(8388607, 16777215), 1, err_word);
        add_row(day_req(2299160, 4320000), 0, none);
        add_row(day_req(2299161, 0), 0, none);
        add_row(day_req(2451545, 0), 0, none);
        add_row(day_req(1721058, 100), 0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_req[i]) begin
            if (dir_known[i] && convert_date(dir_req[i]) !== dir_want[i]) begin
                n_bad++;
                $display("table row %0d disagrees with calculation", i);
            end
            send_word(dir_req[i], 1);
        end
        for (int n = 0; n < 950; n++) begin
            if (n == 800) quiet = 1;
            send_word(rand_req(), !quiet);
        end
        i_valid <= 1'b0;
        quiet = 1;
        wait_cnt = 0;
        while (pending_dates.size() != 0 && wait_cnt < 10000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && pending_dates.size() == 0) begin
            $display("julian_day_calendar_converter_core verification clean");
        end else begin
            $display("julian_day_calendar_converter_core verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("julian_day_calendar_converter_core verification failed");
        $finish;
    end
endmodule
